[rtl/tcm_pkg.sv]
// ----------------------------------------------------------------------------
// tcm_pkg
// Types, wiring tables and mod-26 helpers for the three-rotor cipher machine.
// ----------------------------------------------------------------------------
package tcm_pkg;

	localparam int NLET       = 26;
	localparam int NROT       = 5;
	localparam int NCFG       = 6;
	localparam int TCM_QDEPTH = 4;

	typedef logic [4:0] let_t;
	typedef logic [2:0] rsel_t;
	typedef let_t [NLET-1:0] perm_t;
	typedef perm_t [NROT-1:0] bank_t;

	typedef enum logic {
		REQ_LETTER = 1'b0,
		REQ_LOAD   = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		CFG_LEFT_ROTOR   = 3'd0,
		CFG_MIDDLE_ROTOR = 3'd1,
		CFG_RIGHT_ROTOR  = 3'd2,
		CFG_LEFT_RING    = 3'd3,
		CFG_MIDDLE_RING  = 3'd4,
		CFG_RIGHT_RING   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		req_kind_t req_type;
		let_t      letter;
		let_t      left_start;
		let_t      middle_start;
		let_t      right_start;
	} tcm_req_t;

	typedef struct packed {
		let_t cipher_letter;
		let_t left_now;
		let_t middle_now;
		let_t right_now;
	} tcm_rsp_t;

	typedef struct packed {
		rsel_t left_rotor;
		rsel_t middle_rotor;
		rsel_t right_rotor;
		let_t  left_ring;
		let_t  middle_ring;
		let_t  right_ring;
	} tcm_cfg_t;

	// one letter in flight: current value, rotor offsets, positions to report
	typedef struct packed {
		let_t c;
		let_t sl;
		let_t sm;
		let_t sr;
		let_t left_pos;
		let_t middle_pos;
		let_t right_pos;
	} tcm_job_t;

	function automatic perm_t to_perm(input logic [NLET*8-1:0] s);
		perm_t p;
		for (int i = 0; i < NLET; i++) begin
			p[i] = let_t'(s[(NLET-1-i)*8 +: 8] - 8'd65);
		end
		return p;
	endfunction

	function automatic perm_t invert(input perm_t p);
		perm_t q;
		q = '0;
		for (int i = 0; i < NLET; i++) begin
			q[p[i]] = let_t'(i);
		end
		return q;
	endfunction

	function automatic bank_t build_fwd();
		bank_t b;
		b[0] = to_perm("EKMFLGDQVZNTOWYHXUSPAIBRCJ");
		b[1] = to_perm("AJDKSIRUXBLHWTMCQGZNPYFVOE");
		b[2] = to_perm("BDFHJLCPRTXVZNYEIWGAKMUSQO");
		b[3] = to_perm("ESOVPZJAYQUIRHXLNFTGKDCMWB");
		b[4] = to_perm("VZBRGITYUPSDNHLXAWMJQOFECK");
		return b;
	endfunction

	localparam bank_t WIRE_FWD = build_fwd();

	function automatic bank_t build_bwd();
		bank_t b;
		for (int w = 0; w < NROT; w++) begin
			b[w] = invert(WIRE_FWD[w]);
		end
		return b;
	endfunction

	localparam bank_t WIRE_BWD = build_bwd();
	localparam perm_t REFL     = to_perm("YRUHQSLDPXNGOKMIEBFZCWVJAT");

	// turnover letters Q E V J Z
	localparam let_t [NROT-1:0] NOTCH = {5'd25, 5'd9, 5'd21, 5'd4, 5'd16};

	function automatic let_t red26(input let_t v);
		return (v >= let_t'(NLET)) ? let_t'(v - let_t'(NLET)) : v;
	endfunction

	function automatic let_t inc26(input let_t v);
		return (v == let_t'(NLET-1)) ? let_t'(0) : let_t'(v + 5'd1);
	endfunction

	function automatic let_t add26(input let_t a, input let_t b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= 6'(NLET)) ? let_t'(s - 6'(NLET)) : let_t'(s);
	endfunction

	function automatic let_t sub26(input let_t a, input let_t b);
		logic [5:0] s;
		s = {1'b0, a} + 6'(NLET) - {1'b0, b};
		return (a >= b) ? let_t'(a - b) : let_t'(s);
	endfunction

	function automatic rsel_t sat_sel(input rsel_t v);
		return (v > rsel_t'(NROT-1)) ? rsel_t'(NROT-1) : v;
	endfunction

	function automatic let_t fwd_pass(input rsel_t w, input let_t c, input let_t sh);
		return sub26(WIRE_FWD[w][add26(c, sh)], sh);
	endfunction

	function automatic let_t bwd_pass(input rsel_t w, input let_t c, input let_t sh);
		return sub26(WIRE_BWD[w][add26(c, sh)], sh);
	endfunction

endpackage

[rtl/tcm_front.sv]
// ----------------------------------------------------------------------------
// tcm_front
// Takes requests, holds rotor positions, steps them and queues letter jobs.
// ----------------------------------------------------------------------------
module tcm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  tcm_pkg::tcm_cfg_t  cfg,
	input  logic               req_valid,
	output logic               req_stall,
	input  tcm_pkg::tcm_req_t  req,
	input  logic               q_full,
	output logic               push,
	output tcm_pkg::tcm_job_t  job
);
	import tcm_pkg::*;

	let_t  left_pos_q, middle_pos_q, right_pos_q;
	let_t  left_nx, middle_nx, right_nx;
	logic  accept, mid_at, right_at;
	rsel_t wm, wr;

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;
	assign push      = accept && (req.req_type == REQ_LETTER);

	always_comb begin
		wm       = sat_sel(cfg.middle_rotor);
		wr       = sat_sel(cfg.right_rotor);
		mid_at   = (middle_pos_q == NOTCH[wm]);
		right_at = (right_pos_q == NOTCH[wr]);
		left_nx   = mid_at ? inc26(left_pos_q) : left_pos_q;
		middle_nx = (mid_at || right_at) ? inc26(middle_pos_q) : middle_pos_q;
		right_nx  = inc26(right_pos_q);

		job.c          = red26(req.letter);
		job.sl         = sub26(left_nx, red26(cfg.left_ring));
		job.sm         = sub26(middle_nx, red26(cfg.middle_ring));
		job.sr         = sub26(right_nx, red26(cfg.right_ring));
		job.left_pos   = left_nx;
		job.middle_pos = middle_nx;
		job.right_pos  = right_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_pos_q   <= '0;
			middle_pos_q <= '0;
			right_pos_q  <= '0;
		end else if (accept) begin
			if (req.req_type == REQ_LOAD) begin
				left_pos_q   <= red26(req.left_start);
				middle_pos_q <= red26(req.middle_start);
				right_pos_q  <= red26(req.right_start);
			end else begin
				left_pos_q   <= left_nx;
				middle_pos_q <= middle_nx;
				right_pos_q  <= right_nx;
			end
		end
	end

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_pos_q < let_t'(NLET) && middle_pos_q < let_t'(NLET) &&
		right_pos_q < let_t'(NLET))
		else $error("rotor position out of range");

	a_pos_follows_job: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> right_pos_q == $past(job.right_pos) &&
			middle_pos_q == $past(job.middle_pos) && left_pos_q == $past(job.left_pos))
		else $error("positions differ from queued job");
`endif

endmodule

[rtl/tcm_fifo.sv]
// ----------------------------------------------------------------------------
// tcm_fifo
// Short job queue between the stepping front and the cipher pipeline.
// ----------------------------------------------------------------------------
module tcm_fifo #(
	parameter int DEPTH = tcm_pkg::TCM_QDEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tcm_pkg::tcm_job_t  wdata,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output tcm_pkg::tcm_job_t  rdata
);
	import tcm_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	tcm_job_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full)
		else $error("push into full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule

[rtl/tcm_back.sv]
// ----------------------------------------------------------------------------
// tcm_back
// Six-stage cipher pipeline: three rotors in, reflector, three rotors out.
// ----------------------------------------------------------------------------
module tcm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tcm_pkg::tcm_cfg_t  cfg,
	input  logic               q_empty,
	input  tcm_pkg::tcm_job_t  q_rdata,
	output logic               pop,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output tcm_pkg::tcm_rsp_t  rsp
);
	import tcm_pkg::*;

	logic     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	tcm_job_t job_s1, job_s2, job_s3, job_s4, job_s5, job_s6;
	tcm_job_t n1, n2, n3, n4, n5, n6;
	rsel_t    wl, wm, wr;
	logic     en;

	assign wl  = sat_sel(cfg.left_rotor);
	assign wm  = sat_sel(cfg.middle_rotor);
	assign wr  = sat_sel(cfg.right_rotor);
	assign en  = !(v_s6 && rsp_stall);
	assign pop = en && !q_empty;

	always_comb begin
		n1   = q_rdata;
		n1.c = fwd_pass(wr, q_rdata.c, q_rdata.sr);
		n2   = job_s1;
		n2.c = fwd_pass(wm, job_s1.c, job_s1.sm);
		n3   = job_s2;
		n3.c = REFL[fwd_pass(wl, job_s2.c, job_s2.sl)];
		n4   = job_s3;
		n4.c = bwd_pass(wl, job_s3.c, job_s3.sl);
		n5   = job_s4;
		n5.c = bwd_pass(wm, job_s4.c, job_s4.sm);
		n6   = job_s5;
		n6.c = bwd_pass(wr, job_s5.c, job_s5.sr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s1 <= n1;
			job_s2 <= n2;
			job_s3 <= n3;
			job_s4 <= n4;
			job_s5 <= n5;
			job_s6 <= n6;
		end
	end

	assign rsp_valid         = v_s6;
	assign rsp.cipher_letter = job_s6.c;
	assign rsp.left_now      = job_s6.left_pos;
	assign rsp.middle_now    = job_s6.middle_pos;
	assign rsp.right_now     = job_s6.right_pos;

`ifndef ASSERT_OFF
	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.cipher_letter < let_t'(NLET))
		else $error("cipher letter out of range");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && rsp_stall) |=> $stable(v_s5) && (!v_s5 || $stable(job_s5)) &&
			!$past(pop))
		else $error("pipeline moved while output stalled");
`endif

endmodule

[rtl/three_rotor_cipher_machine.sv]
// ----------------------------------------------------------------------------
// three_rotor_cipher_machine
// Three-rotor cipher with reflector B: front stepper, job queue, cipher pipe.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req): a transfer with req_type LOAD sets
//   the three rotor positions and gives no response; a LETTER transfer steps
//   the rotors (double step at the notches) and yields one response.
//   rsp channel (rsp_valid/rsp_stall/rsp): cipher letter and positions after
//   stepping, in request order.
//   cfg port: rotor selection (I..V as 0..4, larger means V) and ring offsets,
//   written with cfg_we/cfg_addr/cfg_wdata while no letter is in flight.
// Timing: one request per cycle sustained while req_stall is low. A letter
//   accepted at an edge is written into the queue at that edge and then passes
//   through the stages of the cipher pipeline to rsp.
// Stall: rsp_stall on a valid rsp freezes the pipeline; the queue of QUEUE_DEPTH
//   jobs then fills and req_stall rises. Loads pass through the front only.
// Reset: positions A A A, rotors I II III, rings A, queue and pipe empty.
// ----------------------------------------------------------------------------
module three_rotor_cipher_machine #(
	parameter int QUEUE_DEPTH = tcm_pkg::TCM_QDEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [4:0]         cfg_wdata,
	input  logic               req_valid,
	output logic               req_stall,
	input  tcm_pkg::tcm_req_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output tcm_pkg::tcm_rsp_t  rsp
);
	import tcm_pkg::*;

	tcm_cfg_t cfg_q;
	tcm_job_t push_job, head_job;
	logic     push, pop, q_full, q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_rotor   <= rsel_t'(0);
			cfg_q.middle_rotor <= rsel_t'(1);
			cfg_q.right_rotor  <= rsel_t'(2);
			cfg_q.left_ring    <= '0;
			cfg_q.middle_ring  <= '0;
			cfg_q.right_ring   <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_LEFT_ROTOR:   cfg_q.left_rotor   <= cfg_wdata[2:0];
				CFG_MIDDLE_ROTOR: cfg_q.middle_rotor <= cfg_wdata[2:0];
				CFG_RIGHT_ROTOR:  cfg_q.right_rotor  <= cfg_wdata[2:0];
				CFG_LEFT_RING:    cfg_q.left_ring    <= cfg_wdata;
				CFG_MIDDLE_RING:  cfg_q.middle_ring  <= cfg_wdata;
				CFG_RIGHT_RING:   cfg_q.right_ring   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	tcm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.job       (push_job)
	);

	tcm_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_job),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.rdata  (head_job)
	);

	tcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_rdata   (head_job),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
